// ===== hw/rtl/psw_pkg.sv =====
// Shared constants, control structs and arithmetic helpers of the plucked-string synthesizer.
package psw_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int LEN_W         = 9;
    localparam int OFF_W         = 9;
    localparam int S_TDATA_W     = 32;
    localparam int MAX_DELAY_DEF = 512;
    localparam int BODY_TAPS_DEF = 12;
    localparam int COEF_IW       = 4;
    localparam int MUL_A_W       = 17;
    localparam int MUL_B_W       = 16;
    localparam int PROD_W        = MUL_A_W + MUL_B_W;
    localparam int ACC_W         = 40;
    localparam int FRAC_W        = 15;
    localparam int LEN_MIN       = 2;

    localparam logic [LEN_W-1:0] LEN_RESET = 9'd112;

    localparam logic signed [MUL_B_W-1:0] FB_GAIN  = 16'sd16368;
    localparam logic signed [MUL_B_W-1:0] MIX_GAIN = 16'sd1638;

    localparam logic signed [ACC_W-1:0] ROUND_ADD = 40'sd16384;
    localparam logic signed [ACC_W-1:0] SAT_MAX   = 40'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_MIN   = -40'sd32768;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic clr;
        logic load_start;
        logic load_red;
        logic load_wr;
        logic tick_start;
        logic head_cap;
        logic fb1;
        logic fb2;
        logic mix;
        logic tap;
        logic last;
        logic fin;
    } psw_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic wrap_done;
        logic tap_last;
        logic out_free;
    } psw_sts_t;

    function automatic logic signed [MUL_B_W-1:0] body_coef(input logic [COEF_IW-1:0] idx);
        logic signed [MUL_B_W-1:0] c;
        case (idx)
            4'd0:    c = 16'sd29370;
            4'd1:    c = -16'sd30199;
            4'd2:    c = 16'sd22922;
            4'd3:    c = -16'sd14537;
            4'd4:    c = 16'sd12662;
            4'd5:    c = -16'sd11004;
            4'd6:    c = 16'sd10633;
            4'd7:    c = -16'sd11314;
            4'd8:    c = 16'sd14191;
            4'd9:    c = -16'sd14856;
            4'd10:   c = 16'sd10894;
            4'd11:   c = -16'sd4235;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Rounds half up at the Q15 point and saturates to a 16-bit sample.
    function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] r;
        r = (x + ROUND_ADD) >>> FRAC_W;
        if (r > SAT_MAX) begin
            r = SAT_MAX;
        end else if (r < SAT_MIN) begin
            r = SAT_MIN;
        end
        return r[SAMPLE_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/psw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module psw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/psw_ctrl.sv =====
// Sequencer that steps the datapath through clear, load and tick operations.
module psw_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              req_type,
    input  psw_pkg::psw_sts_t sts,
    output psw_pkg::psw_cmd_t cmd
);
    import psw_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_LOAD  = 10'b0000000100,
        S_READ  = 10'b0000001000,
        S_FB1   = 10'b0000010000,
        S_FB2   = 10'b0000100000,
        S_MIX   = 10'b0001000000,
        S_TAP   = 10'b0010000000,
        S_LAST  = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (req_type == REQ_TICK) begin
                        cmd.tick_start = 1'b1;
                        state_next     = S_READ;
                    end else begin
                        cmd.load_start = 1'b1;
                        state_next     = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (sts.wrap_done) begin
                    cmd.load_wr = 1'b1;
                    state_next  = S_IDLE;
                end else begin
                    cmd.load_red = 1'b1;
                end
            end
            S_READ: begin
                cmd.head_cap = 1'b1;
                state_next   = S_FB1;
            end
            S_FB1: begin
                cmd.fb1    = 1'b1;
                state_next = S_FB2;
            end
            S_FB2: begin
                cmd.fb2    = 1'b1;
                state_next = S_MIX;
            end
            S_MIX: begin
                cmd.mix    = 1'b1;
                state_next = S_TAP;
            end
            S_TAP: begin
                cmd.tap = 1'b1;
                if (sts.tap_last) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                cmd.last   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (sts.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/psw_datapath.sv =====
// String delay lines, shared multiplier, body filter and output register.
module psw_datapath #(
    parameter int MAX_DELAY = psw_pkg::MAX_DELAY_DEF,
    parameter int BODY_TAPS = psw_pkg::BODY_TAPS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  psw_pkg::psw_cmd_t                     cmd,
    output psw_pkg::psw_sts_t                     sts,
    input  logic [psw_pkg::OFF_W-1:0]             load_offset,
    input  logic signed [psw_pkg::SAMPLE_W-1:0]   load_value,
    input  logic                                  cfg_we,
    input  logic [psw_pkg::LEN_W-1:0]             cfg_len,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic signed [psw_pkg::SAMPLE_W-1:0]   sample_out
);
    import psw_pkg::*;

    localparam int AW = $clog2(MAX_DELAY);
    localparam int SW = ((AW > OFF_W) ? AW : OFF_W) + 1;
    localparam int CW = (AW > LEN_W) ? AW : LEN_W;
    localparam int PW = AW + 1;
    localparam int TW = (BODY_TAPS > 1) ? $clog2(BODY_TAPS) : 1;

    logic [LEN_W-1:0]                 len_reg;
    logic [AW-1:0]                    head_reg;
    logic [AW-1:0]                    clr_reg;
    logic signed [SAMPLE_W-1:0]       prev1_reg;
    logic signed [SAMPLE_W-1:0]       prev2_reg;
    logic signed [SAMPLE_W-1:0]       hd1_reg;
    logic signed [SAMPLE_W-1:0]       hd2_reg;
    logic [SW-1:0]                    lsum_reg;
    logic signed [SAMPLE_W-1:0]       lval_reg;
    logic signed [PROD_W-1:0]         mul_reg;
    logic signed [ACC_W-1:0]          acc_reg;
    logic [TW-1:0]                    tap_reg;
    logic signed [SAMPLE_W-1:0]       hist_reg [BODY_TAPS];
    logic signed [SAMPLE_W-1:0]       out_reg;
    logic                             ovalid_reg;

    logic [CW-1:0]                    len_clamp;
    logic [AW-1:0]                    len_eff;
    logic [PW-1:0]                    sum1;
    logic [PW-1:0]                    sum2;
    logic [AW-1:0]                    pos1;
    logic [AW-1:0]                    pos2;
    logic signed [MUL_A_W-1:0]        mul_a;
    logic signed [MUL_B_W-1:0]        mul_b;
    logic signed [SAMPLE_W-1:0]       fb_val;
    logic signed [ACC_W-1:0]          tap_term;
    logic signed [SAMPLE_W-1:0]       y_val;
    logic                             tap_last;

    logic                             we1;
    logic                             we2;
    logic [AW-1:0]                    waddr1;
    logic [AW-1:0]                    waddr2;
    logic [SAMPLE_W-1:0]              wdata1;
    logic [SAMPLE_W-1:0]              wdata2;
    logic [SAMPLE_W-1:0]              rdata1;
    logic [SAMPLE_W-1:0]              rdata2;

    always_comb begin
        len_clamp = CW'(len_reg);
        if (len_clamp < CW'(LEN_MIN)) begin
            len_clamp = CW'(LEN_MIN);
        end else if (len_clamp > CW'(MAX_DELAY - 2)) begin
            len_clamp = CW'(MAX_DELAY - 2);
        end
    end

    assign len_eff = len_clamp[AW-1:0];
    assign sum1    = PW'(head_reg) + PW'(len_eff);
    assign sum2    = sum1 + PW'(1);
    assign pos1    = (sum1 >= PW'(MAX_DELAY)) ? AW'(sum1 - PW'(MAX_DELAY)) : sum1[AW-1:0];
    assign pos2    = (sum2 >= PW'(MAX_DELAY)) ? AW'(sum2 - PW'(MAX_DELAY)) : sum2[AW-1:0];

    always_comb begin
        mul_a = MUL_A_W'(hist_reg[0]);
        mul_b = body_coef(COEF_IW'(tap_reg));
        if (cmd.fb1) begin
            mul_a = MUL_A_W'(hd1_reg) + MUL_A_W'(prev1_reg);
            mul_b = FB_GAIN;
        end else if (cmd.fb2) begin
            mul_a = MUL_A_W'(hd2_reg) + MUL_A_W'(prev2_reg);
            mul_b = FB_GAIN;
        end else if (cmd.mix) begin
            mul_a = MUL_A_W'(hd1_reg) + MUL_A_W'(hd2_reg);
            mul_b = MIX_GAIN;
        end
    end

    assign fb_val   = round_sat(ACC_W'(mul_reg));
    assign tap_term = ACC_W'(mul_reg) <<< 1;
    assign y_val    = round_sat(acc_reg);
    assign tap_last = (tap_reg == TW'(BODY_TAPS - 1));

    assign we1    = cmd.clr | cmd.load_wr | cmd.fb2;
    assign we2    = cmd.clr | cmd.load_wr | cmd.mix;
    assign waddr1 = cmd.clr ? clr_reg : (cmd.load_wr ? lsum_reg[AW-1:0] : pos1);
    assign waddr2 = cmd.clr ? clr_reg : (cmd.load_wr ? lsum_reg[AW-1:0] : pos2);
    assign wdata1 = cmd.clr ? '0 : (cmd.load_wr ? lval_reg : fb_val);
    assign wdata2 = cmd.clr ? '0 : (cmd.load_wr ? lval_reg : fb_val);

    psw_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_line1 (
        .aclk  (aclk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (wdata1),
        .re    (cmd.tick_start),
        .raddr (head_reg),
        .rdata (rdata1)
    );

    psw_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_line2 (
        .aclk  (aclk),
        .we    (we2),
        .waddr (waddr2),
        .wdata (wdata2),
        .re    (cmd.tick_start),
        .raddr (head_reg),
        .rdata (rdata2)
    );

    always_ff @(posedge aclk) begin
        mul_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (cmd.head_cap) begin
            hd1_reg <= rdata1;
            hd2_reg <= rdata2;
        end
        if (cmd.load_start) begin
            lsum_reg <= SW'(head_reg) + SW'(load_offset);
            lval_reg <= load_value;
        end else if (cmd.load_red) begin
            lsum_reg <= lsum_reg - SW'(MAX_DELAY);
        end
        if (cmd.tap) begin
            if (tap_reg == '0) begin
                acc_reg <= ACC_W'(mul_reg);
            end else begin
                acc_reg <= acc_reg + tap_term;
            end
        end else if (cmd.last) begin
            acc_reg <= acc_reg + tap_term;
        end
        if (cmd.fin) begin
            out_reg <= y_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= LEN_RESET;
            head_reg   <= '0;
            clr_reg    <= '0;
            prev1_reg  <= '0;
            prev2_reg  <= '0;
            tap_reg    <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < BODY_TAPS; i++) begin
                hist_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                len_reg <= cfg_len;
            end
            if (cmd.clr) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.mix) begin
                prev1_reg <= hd1_reg;
                prev2_reg <= hd2_reg;
                head_reg  <= (head_reg == AW'(MAX_DELAY - 1)) ? '0 : head_reg + AW'(1);
            end
            if (cmd.tap) begin
                tap_reg <= tap_last ? '0 : tap_reg + TW'(1);
                for (int i = 0; i < BODY_TAPS - 1; i++) begin
                    hist_reg[i] <= hist_reg[i+1];
                end
                hist_reg[BODY_TAPS-1] <= hist_reg[0];
            end else if (cmd.fin) begin
                for (int i = BODY_TAPS - 1; i > 0; i--) begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                hist_reg[0] <= y_val;
            end
            if (cmd.fin) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign sts.clr_last  = (clr_reg == AW'(MAX_DELAY - 1));
    assign sts.wrap_done = (lsum_reg < SW'(MAX_DELAY));
    assign sts.tap_last  = tap_last;
    assign sts.out_free  = !ovalid_reg || m_tready;

    assign m_tvalid   = ovalid_reg;
    assign sample_out = out_reg;

endmodule

// ===== hw/rtl/plucked_string_waveguide_synth.sv =====
// Top level of the two-string plucked-string synthesizer with body filter.
//
// Channel   Direction  Contents
// s_        in         tuser: req_type; tdata: load_offset, load_value
// m_        out        tdata: sample_out
// cfg_      in         data: loop_length
//
// After reset a clearing pass zeroes every address of both delay lines; no input
// transaction is taken during it, while configuration writes are taken at any time.
// A load registers head plus offset, reduces it below MAX_DELAY, then writes both lines.
// A tick runs on the single shared multiplier, which serves both feedback products, the mix
// and every body tap in turn.
// A waiting result stalls only the final state, S_FIN, of the next tick; loads go on meanwhile.
module plucked_string_waveguide_synth #(
    parameter int MAX_DELAY = psw_pkg::MAX_DELAY_DEF,
    parameter int BODY_TAPS = psw_pkg::BODY_TAPS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [psw_pkg::S_TDATA_W-1:0]     s_tdata,  // load_offset[8:0], load_value[24:9]
    input  logic [0:0]                        s_tuser,  // req_type[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [psw_pkg::SAMPLE_W-1:0]      m_tdata,  // sample_out[15:0]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psw_pkg::LEN_W-1:0]         cfg_data
);
    import psw_pkg::*;

    psw_cmd_t                   cmd;
    psw_sts_t                   sts;
    logic [OFF_W-1:0]           load_offset;
    logic signed [SAMPLE_W-1:0] load_value;
    logic signed [SAMPLE_W-1:0] sample_out;

    assign load_offset = s_tdata[OFF_W-1:0];
    assign load_value  = s_tdata[OFF_W+SAMPLE_W-1:OFF_W];
    assign cfg_ready   = 1'b1;
    assign m_tdata     = sample_out;

    psw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser[0]),
        .sts      (sts),
        .cmd      (cmd)
    );

    psw_datapath #(
        .MAX_DELAY (MAX_DELAY),
        .BODY_TAPS (BODY_TAPS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .load_offset (load_offset),
        .load_value  (load_value),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_len     (cfg_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .sample_out  (sample_out)
    );

endmodule

// ===== verif/plucked_string_waveguide_synth_tb.sv =====
// Self-checking testbench for the two-string plucked-string synthesizer with body filter.
`timescale 1ns / 100ps

module plucked_string_waveguide_synth_tb;

    localparam int LINE_DEPTH = 512;
    localparam int TAP_COUNT  = 12;
    localparam int LOOP_GAIN  = 16368;
    localparam int MIX_LEVEL  = 1638;
    localparam int LEN_FLOOR  = 2;
    localparam int LEN_CEIL   = LINE_DEPTH - 2;

    class string_synth_model;
        logic signed [15:0] line_a [LINE_DEPTH];
        logic signed [15:0] line_b [LINE_DEPTH];
        logic [8:0]         head;
        logic [8:0]         loop_len;
        int                 prev_a;
        int                 prev_b;
        int                 body_hist [TAP_COUNT];
        logic signed [15:0] sample_queue [$];
        int                 errors;

        function new();
            foreach (line_a[i]) begin
                line_a[i] = '0;
                line_b[i] = '0;
            end
            foreach (body_hist[i]) begin
                body_hist[i] = 0;
            end
            head     = '0;
            loop_len = 9'd112;
            prev_a   = 0;
            prev_b   = 0;
            errors   = 0;
        endfunction

        function logic signed [15:0] clip16(longint v);
            if (v > 32767) begin
                return 16'sh7fff;
            end
            if (v < -32768) begin
                return 16'sh8000;
            end
            return v[15:0];
        endfunction

        function longint round_q15(longint x);
            return (x + 64'sd16384) >>> 15;
        endfunction

        function int body_gain(int k);
            case (k)
                0:       return 29370;
                1:       return -30199;
                2:       return 22922;
                3:       return -14537;
                4:       return 12662;
                5:       return -11004;
                6:       return 10633;
                7:       return -11314;
                8:       return 14191;
                9:       return -14856;
                10:      return 10894;
                11:      return -4235;
                default: return 0;
            endcase
        endfunction

        function void take_request(logic req, logic [8:0] off, logic signed [15:0] val);
            int                 len;
            int                 h1;
            int                 h2;
            longint             acc;
            logic [8:0]         p1;
            logic [8:0]         p2;
            logic signed [15:0] y;
            if (req == psw_pkg::REQ_LOAD) begin
                p1 = head + off;
                line_a[p1] = val;
                line_b[p1] = val;
                return;
            end
            len = loop_len;
            if (len < LEN_FLOOR) begin
                len = LEN_FLOOR;
            end
            if (len > LEN_CEIL) begin
                len = LEN_CEIL;
            end
            h1 = line_a[head];
            h2 = line_b[head];
            p1 = head + len[8:0];
            p2 = head + len[8:0] + 9'd1;
            line_a[p1] = clip16(round_q15(longint'(h1 + prev_a) * LOOP_GAIN));
            line_b[p2] = clip16(round_q15(longint'(h2 + prev_b) * LOOP_GAIN));
            prev_a = h1;
            prev_b = h2;
            head   = head + 9'd1;
            acc = longint'(h1 + h2) * MIX_LEVEL;
            for (int k = 0; k < TAP_COUNT; k++) begin
                acc += longint'(body_hist[k]) * body_gain(k) * 2;
            end
            y = clip16(round_q15(acc));
            for (int k = TAP_COUNT - 1; k > 0; k--) begin
                body_hist[k] = body_hist[k-1];
            end
            body_hist[0] = y;
            sample_queue.push_back(y);
        endfunction

        function void check_sample(logic [15:0] got);
            logic signed [15:0] want;
            if (sample_queue.size() == 0) begin
                $error("sample_out: expected none, actual %0d", $signed(got));
                errors++;
                return;
            end
            want = sample_queue.pop_front();
            if (want !== got) begin
                $error("sample_out: expected %0d, actual %0d", want, $signed(got));
                errors++;
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [psw_pkg::S_TDATA_W-1:0]   s_tdata;   // load_offset[8:0], load_value[24:9]
    logic [0:0]                      s_tuser;   // req_type[0]
    logic                            m_tvalid;
    logic                            m_tready;
    logic [psw_pkg::SAMPLE_W-1:0]    m_tdata;   // sample_out[15:0]
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [psw_pkg::LEN_W-1:0]       cfg_data;

    string_synth_model sb;
    bit                quiet;
    bit                sink_hold;
    int                sent_items;

    plucked_string_waveguide_synth uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("plucked_string_waveguide_synth: mismatch");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.loop_len = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                sb.take_request(s_tuser[0], s_tdata[8:0], s_tdata[24:9]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_sample(m_tdata);
            end
        end
    end

    // Sink side: random stalls, one long hold on request, none near the end.
    initial begin
        int span;
        m_tready = 1'b0;
        forever begin
            if (sink_hold) begin
                sink_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                span = $urandom_range(1, 15);
                m_tready <= 1'b0;
                repeat (span) @(posedge aclk);
            end else begin
                span = $urandom_range(1, 20);
                m_tready <= 1'b1;
                repeat (span) @(posedge aclk);
            end
        end
    end

    task automatic send_request(logic req, logic [8:0] off, logic [15:0] val);
        int gap;
        s_tuser  <= req;
        s_tdata  <= {7'd0, val, off};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent_items++;
        if (sent_items >= 560) begin
            quiet = 1'b1;
        end
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_loop_length(logic [8:0] len);
        s_tvalid <= 1'b0;
        while (sb.sample_queue.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_data  <= len;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic ring_string(int len);
        int span;
        int loads;
        int ticks;
        span = len;
        if (span < LEN_FLOOR) begin
            span = LEN_FLOOR;
        end
        if (span > LEN_CEIL) begin
            span = LEN_CEIL;
        end
        loads = $urandom_range(2, (span + 1 < 24) ? span + 1 : 24);
        for (int i = 0; i < loads; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_request(1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                             16'($urandom));
            end else begin
                send_request(psw_pkg::REQ_LOAD, 9'(i), 16'($urandom));
            end
        end
        ticks = $urandom_range(20, 60);
        for (int i = 0; i < ticks; i++) begin
            send_request(psw_pkg::REQ_TICK, 9'($urandom_range(0, 511)), 16'($urandom));
        end
    endtask

    initial begin
        int phase;
        int len;
        sb         = new();
        quiet      = 1'b0;
        sink_hold  = 1'b0;
        sent_items = 0;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Field extremes and offsets around and past the first string's length.
        send_request(psw_pkg::REQ_LOAD, 9'd0, 16'h7fff);
        send_request(psw_pkg::REQ_LOAD, 9'd511, 16'h8000);
        send_request(psw_pkg::REQ_LOAD, 9'd111, 16'h8001);
        send_request(psw_pkg::REQ_LOAD, 9'd112, 16'hb1e0);
        send_request(psw_pkg::REQ_LOAD, 9'd113, 16'h5555);
        send_request(psw_pkg::REQ_LOAD, 9'h0aa, 16'haaaa);
        send_request(psw_pkg::REQ_LOAD, 9'h155, 16'h5555);
        for (int i = 0; i < 4; i++) begin
            send_request(psw_pkg::REQ_TICK, 9'h1ff, 16'hffff);
        end

        // A length below the legal range clamps to the shortest string.
        write_loop_length(9'd0);
        send_request(psw_pkg::REQ_LOAD, 9'd0, 16'h7fff);
        send_request(psw_pkg::REQ_LOAD, 9'd1, 16'h8000);
        send_request(psw_pkg::REQ_LOAD, 9'd2, 16'h7fff);
        for (int i = 0; i < 6; i++) begin
            send_request(psw_pkg::REQ_TICK, 9'd0, 16'h0000);
        end

        phase = 0;
        while (sent_items < 650) begin
            case (phase)
                0:       len = 510;
                1:       len = 511;
                2:       len = 1;
                3:       len = 2;
                default: len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                           : $urandom_range(2, 40);
            endcase
            write_loop_length(9'(len));
            if (phase == 4) begin
                sink_hold = 1'b1;
            end
            ring_string(len);
            phase++;
        end

        s_tvalid <= 1'b0;
        while (sb.sample_queue.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("plucked_string_waveguide_synth: match");
        end else begin
            $display("plucked_string_waveguide_synth: mismatch");
        end
        $finish;
    end

endmodule
